FILE: rtl/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg: shared types and constants for the gradient colormap lookup
// Control point layout, register codes, reset values and pipeline widths.
// ----------------------------------------------------------------------------
package gcl_pkg;

   localparam int NUM_POINTS     = 6;
   localparam int NUM_SEGS       = NUM_POINTS - 1;
   localparam int MAX_POINTS     = 6;
   localparam int TABLE_ENTRIES  = 256;

   localparam int IDX_W          = 8;
   localparam int POS_W          = 9;
   localparam int COL_W          = 32;
   localparam int CH_W           = 8;
   localparam int NUM_CH         = COL_W / CH_W;
   localparam int SEG_W          = 3;
   localparam int NUM_W          = 17;
   localparam int DIV_STAGES     = 4;
   localparam int BITS_PER_STAGE = CH_W / DIV_STAGES;

   localparam int ADDR_W         = 6;
   localparam int DATA_W         = 64;
   localparam int REG_SEL_W      = 3;

   // register codes, one per 8-byte slot
   localparam logic [REG_SEL_W-1:0] REG_POINT_ZERO    = 3'd0;
   localparam logic [REG_SEL_W-1:0] REG_POINT_FIVE    = 3'd5;
   localparam logic [REG_SEL_W-1:0] REG_SEGMENT_COUNT = 3'd6;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [COL_W-1:0] color;
   } point_type;

   typedef struct packed {
      logic valid;
      logic covered;
   } ctl_type;

   typedef logic [NUM_W-1:0] num_type;

   localparam logic [POS_W+COL_W-1:0] POINT_RESET [NUM_POINTS] = '{
      41'h000FF202020,
      41'h019FF2030A0,
      41'h032FFA040A0,
      41'h04BFFFF9040,
      41'h064FFFFFFFF,
      41'h100FFFFFFFF
   };

   localparam logic [SEG_W-1:0] SEG_COUNT_RESET = 3'd5;
   localparam logic [SEG_W-1:0] SEG_LIMIT       = SEG_W'(MAX_POINTS - 1);

endpackage

FILE: rtl/gcl_divider.sv
// ----------------------------------------------------------------------------
// gcl_divider: pipelined restoring divider, four color channels in parallel
// Retires two quotient bits per stage; control rides along with the data.
// ----------------------------------------------------------------------------
module gcl_divider (
   input  logic                                      clock,
   input  logic                                      reset,
   input  gcl_pkg::ctl_type                          in_ctl,
   input  gcl_pkg::num_type [gcl_pkg::NUM_CH-1:0]    in_num,
   input  logic [gcl_pkg::POS_W-1:0]                 in_dist,
   output gcl_pkg::ctl_type                          out_ctl,
   output logic [gcl_pkg::COL_W-1:0]                 out_quo
);
   import gcl_pkg::*;

   localparam int LAST = DIV_STAGES - 1;

   ctl_type                         ctl_ff   [DIV_STAGES];
   ctl_type                         ctl_in   [DIV_STAGES];
   num_type    [NUM_CH-1:0]         rem_ff   [DIV_STAGES];
   num_type    [NUM_CH-1:0]         rem_in   [DIV_STAGES];
   logic [NUM_CH-1:0][CH_W-1:0]     quo_ff   [DIV_STAGES];
   logic [NUM_CH-1:0][CH_W-1:0]     quo_in   [DIV_STAGES];
   logic [POS_W-1:0]                dist_ff  [DIV_STAGES];
   logic [POS_W-1:0]                dist_in  [DIV_STAGES];

   ctl_type                         src_ctl  [DIV_STAGES];
   num_type    [NUM_CH-1:0]         src_rem  [DIV_STAGES];
   logic [NUM_CH-1:0][CH_W-1:0]     src_quo  [DIV_STAGES];
   logic [POS_W-1:0]                src_dist [DIV_STAGES];

   // stage sources: the first stage takes the port, the rest the stage before
   always_comb begin
      src_ctl[0]  = in_ctl;
      src_rem[0]  = in_num;
      src_quo[0]  = '0;
      src_dist[0] = in_dist;
      for (int s = 1; s < DIV_STAGES; s++) begin
         src_ctl[s]  = ctl_ff[s-1];
         src_rem[s]  = rem_ff[s-1];
         src_quo[s]  = quo_ff[s-1];
         src_dist[s] = dist_ff[s-1];
      end
   end

   // trial subtract of the shifted divisor, most significant bit first
   always_comb begin
      num_type         r;
      num_type         sh;
      logic [CH_W-1:0] q;
      int              b;
      for (int s = 0; s < DIV_STAGES; s++) begin
         ctl_in[s]  = src_ctl[s];
         dist_in[s] = src_dist[s];
         for (int c = 0; c < NUM_CH; c++) begin
            r = src_rem[s][c];
            q = src_quo[s][c];
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
               b  = CH_W - 1 - s * BITS_PER_STAGE - j;
               sh = NUM_W'(src_dist[s]) << b;
               if (r >= sh) begin
                  r    = r - sh;
                  q[b] = 1'b1;
               end
            end
            rem_in[s][c] = r;
            quo_in[s][c] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            ctl_ff[s] <= '0;
         end
      end else begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            ctl_ff[s] <= ctl_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         rem_ff[s]  <= rem_in[s];
         quo_ff[s]  <= quo_in[s];
         dist_ff[s] <= dist_in[s];
      end
   end

   assign out_ctl = ctl_ff[LAST];
   assign out_quo = quo_ff[LAST];

   // control must line up with the data it was launched with
   assert property (@(posedge clock) disable iff (reset)
      out_ctl.valid |-> $past(in_ctl.valid, DIV_STAGES))
      else $error("divider valid out of step with its input");

   assert property (@(posedge clock) disable iff (reset)
      out_ctl.valid |-> (out_ctl.covered == $past(in_ctl.covered, DIV_STAGES)))
      else $error("divider covered flag out of step with its input");

   // a finished division leaves a remainder below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (out_ctl.valid && out_ctl.covered) |->
         (rem_ff[LAST][0] < NUM_W'(dist_ff[LAST])) &&
         (rem_ff[LAST][1] < NUM_W'(dist_ff[LAST])) &&
         (rem_ff[LAST][2] < NUM_W'(dist_ff[LAST])) &&
         (rem_ff[LAST][3] < NUM_W'(dist_ff[LAST])))
      else $error("divider remainder not below divisor");

endmodule

FILE: rtl/gradient_colormap_lookup.sv
// ----------------------------------------------------------------------------
// gradient_colormap_lookup: piecewise-linear ARGB gradient color per index
// Segment match, operand setup, channel products and a pipelined divider.
// ----------------------------------------------------------------------------
// Each index passes the stage 1 to 4 registers and then the divider stages before its result strobes.
// Throughput: one index per cycle; busy never rises, the pipeline has no holds.
// The depth is set by the 4-stage divider behind 4 capture/match/operand/product stages.
// Reset clears every stage valid bit and restores the control points and the
// segment count to their defaults; the receiver cannot stall the result path.
// ----------------------------------------------------------------------------
module gradient_colormap_lookup (
   input  logic                            clock,
   input  logic                            reset,
   // index channel
   input  logic                            start,
   output logic                            busy,
   input  logic [gcl_pkg::IDX_W-1:0]       req_index,
   // result channel
   output logic                            rsp_strobe,
   output logic [gcl_pkg::COL_W-1:0]       rsp_color,
   output logic                            rsp_covered,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gcl_pkg::ADDR_W-1:0]      paddr,
   input  logic [gcl_pkg::DATA_W-1:0]      pwdata,
   output logic [gcl_pkg::DATA_W-1:0]      prdata,
   output logic                            pready
);
   import gcl_pkg::*;

   localparam int PIPE_DEPTH = 4 + DIV_STAGES;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   point_type               point_ff [NUM_POINTS];
   point_type               point_in [NUM_POINTS];
   logic [SEG_W-1:0]        segment_count_ff;
   logic [SEG_W-1:0]        segment_count_in;
   logic                    csr_write;
   logic [REG_SEL_W-1:0]    csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_sel   = paddr[ADDR_W-1:3];

   // Decode the write; slots beyond the list drop the transfer.
   always_comb begin
      for (int i = 0; i < NUM_POINTS; i++) begin
         point_in[i] = point_ff[i];
      end
      segment_count_in = segment_count_ff;
      if (csr_write) begin
         unique case (csr_sel) inside
            [REG_POINT_ZERO:REG_POINT_FIVE]: begin
               point_in[csr_sel] = pwdata[POS_W+COL_W-1:0];
            end
            REG_SEGMENT_COUNT: begin
               segment_count_in = pwdata[SEG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel) inside
         [REG_POINT_ZERO:REG_POINT_FIVE]: prdata = DATA_W'(point_ff[csr_sel]);
         REG_SEGMENT_COUNT:               prdata = DATA_W'(segment_count_ff);
         default:                         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_POINTS; i++) begin
            point_ff[i] <= POINT_RESET[i];
         end
         segment_count_ff <= SEG_COUNT_RESET;
      end else begin
         for (int i = 0; i < NUM_POINTS; i++) begin
            point_ff[i] <= point_in[i];
         end
         segment_count_ff <= segment_count_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: capture the index on an accepted transfer
   // ------------------------------------------------------------------
   ctl_type              s1_ctl_ff, s1_ctl_in;
   logic [IDX_W-1:0]     s1_index_ff, s1_index_in;

   // Every stage advances each cycle, so a new index is always welcome.
   assign busy = 1'b0;

   always_comb begin
      s1_ctl_in.valid   = start & ~busy;
      s1_ctl_in.covered = 1'b0;
      s1_index_in       = req_index;
   end

   // ------------------------------------------------------------------
   // Stage 2: find the lowest segment with start <= index < end, and
   // latch its end points so later stages never look at live config
   // ------------------------------------------------------------------
   ctl_type              s2_ctl_ff, s2_ctl_in;
   logic [IDX_W-1:0]     s2_index_ff, s2_index_in;
   logic [POS_W-1:0]     s2_v1_ff, s2_v1_in;
   logic [POS_W-1:0]     s2_v2_ff, s2_v2_in;
   logic [COL_W-1:0]     s2_c1_ff, s2_c1_in;
   logic [COL_W-1:0]     s2_c2_ff, s2_c2_in;

   logic [SEG_W-1:0]     segs_used;
   logic [SEG_W-1:0]     seg_pick;
   logic                 seg_found;
   logic                 in_table;
   logic [POS_W-1:0]     idx_wide;

   always_comb begin
      // clamp an oversized count to the number of segments the points allow
      segs_used = (segment_count_ff > SEG_LIMIT) ? SEG_LIMIT : segment_count_ff;
      idx_wide  = POS_W'(s1_index_ff);
      in_table  = idx_wide < POS_W'(TABLE_ENTRIES);
      seg_found = 1'b0;
      seg_pick  = '0;
      // walk down so the lowest matching segment is the one kept
      for (int k = NUM_SEGS - 1; k >= 0; k--) begin
         if ((SEG_W'(k) < segs_used) &&
             (point_ff[k].pos <= idx_wide) &&
             (idx_wide < point_ff[k+1].pos)) begin
            seg_found = 1'b1;
            seg_pick  = SEG_W'(k);
         end
      end
      s2_ctl_in.valid   = s1_ctl_ff.valid;
      s2_ctl_in.covered = seg_found & in_table;
      s2_index_in       = s1_index_ff;
      s2_v1_in          = point_ff[seg_pick].pos;
      s2_v2_in          = point_ff[seg_pick + SEG_W'(1)].pos;
      s2_c1_in          = point_ff[seg_pick].color;
      s2_c2_in          = point_ff[seg_pick + SEG_W'(1)].color;
   end

   // ------------------------------------------------------------------
   // Stage 3: segment length and the two blend weights
   // ------------------------------------------------------------------
   ctl_type              s3_ctl_ff, s3_ctl_in;
   logic [POS_W-1:0]     s3_dist_ff, s3_dist_in;
   logic [IDX_W-1:0]     s3_d_ff, s3_d_in;
   logic [POS_W-1:0]     s3_wd_ff, s3_wd_in;
   logic [COL_W-1:0]     s3_c1_ff, s3_c1_in;
   logic [COL_W-1:0]     s3_c2_ff, s3_c2_in;

   always_comb begin
      s3_ctl_in  = s2_ctl_ff;
      s3_dist_in = s2_v2_ff - s2_v1_ff;
      // start sits at or below the index on a hit, so the low byte suffices
      s3_d_in    = s2_index_ff - s2_v1_ff[IDX_W-1:0];
      // dist - d collapses to end - index
      s3_wd_in   = s2_v2_ff - POS_W'(s2_index_ff);
      s3_c1_in   = s2_c1_ff;
      s3_c2_in   = s2_c2_ff;
   end

   // ------------------------------------------------------------------
   // Stage 4: weighted channel sums d*c2 + (dist-d)*c1
   // ------------------------------------------------------------------
   ctl_type                   s4_ctl_ff, s4_ctl_in;
   num_type [NUM_CH-1:0]      s4_num_ff, s4_num_in;
   logic [POS_W-1:0]          s4_dist_ff, s4_dist_in;

   always_comb begin
      s4_ctl_in  = s3_ctl_ff;
      s4_dist_in = s3_dist_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         s4_num_in[c] = NUM_W'(s3_d_ff)  * NUM_W'(s3_c2_ff[c*CH_W +: CH_W]) +
                        NUM_W'(s3_wd_ff) * NUM_W'(s3_c1_ff[c*CH_W +: CH_W]);
      end
   end

   // ------------------------------------------------------------------
   // Pipeline registers: valid bits reset, payload free-running
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s2_ctl_in;
         s3_ctl_ff <= s3_ctl_in;
         s4_ctl_ff <= s4_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff <= s1_index_in;
      s2_index_ff <= s2_index_in;
      s2_v1_ff    <= s2_v1_in;
      s2_v2_ff    <= s2_v2_in;
      s2_c1_ff    <= s2_c1_in;
      s2_c2_ff    <= s2_c2_in;
      s3_dist_ff  <= s3_dist_in;
      s3_d_ff     <= s3_d_in;
      s3_wd_ff    <= s3_wd_in;
      s3_c1_ff    <= s3_c1_in;
      s3_c2_ff    <= s3_c2_in;
      s4_num_ff   <= s4_num_in;
      s4_dist_ff  <= s4_dist_in;
   end

   // ------------------------------------------------------------------
   // Stages 5 to 8: divide each channel sum by the segment length
   // ------------------------------------------------------------------
   ctl_type              div_ctl;
   logic [COL_W-1:0]     div_quo;

   gcl_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (s4_ctl_ff),
      .in_num   (s4_num_ff),
      .in_dist  (s4_dist_ff),
      .out_ctl  (div_ctl),
      .out_quo  (div_quo)
   );

   // Present each result for one cycle; drop the color when uncovered.
   assign rsp_strobe  = div_ctl.valid;
   assign rsp_covered = div_ctl.covered;
   assign rsp_color   = div_ctl.covered ? div_quo : '0;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result transfer without a matching index transfer");

   assert property (@(posedge clock) disable iff (reset)
      (s3_ctl_ff.valid && s3_ctl_ff.covered) |->
         ((s3_dist_ff != '0) && (POS_W'(s3_d_ff) < s3_dist_ff)))
      else $error("covered item with empty segment or offset past its end");

   assert property (@(posedge clock) disable iff (reset)
      (s3_ctl_ff.valid && s3_ctl_ff.covered) |->
         ((POS_W'(s3_d_ff) + s3_wd_ff) == s3_dist_ff))
      else $error("blend weights do not sum to the segment length");

endmodule
